/* hdl/tde_pkg.sv */
// Shared constants, codes and types of the trie dictionary engine.
package tde_pkg;

  localparam int NODE_COUNT    = 1024;
  localparam int ALPHABET_SIZE = 26;

  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int FREE_W     = $clog2(NODE_COUNT + 1);
  localparam int SLOT_COUNT = NODE_COUNT * ALPHABET_SIZE;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);

  localparam int OP_W     = 2;
  localparam int LETTER_W = 5;
  localparam int ANS_W    = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_PREFIX = 2'd2;

  localparam logic [ANS_W-1:0] ANS_NO   = 2'd0;
  localparam logic [ANS_W-1:0] ANS_YES  = 2'd1;
  localparam logic [ANS_W-1:0] ANS_FULL = 2'd2;

  // One classified letter on its way from the front to the back.
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [LETTER_W-1:0] letter;
    logic                last;
    logic                op_bad;
    logic                letter_bad;
  } item_t;

endpackage

/* hdl/tde_front.sv */
// Front end: accepts letters and classifies opcode and letter range.
module tde_front (
  input  logic                           start,
  input  logic [tde_pkg::OP_W-1:0]       opcode,
  input  logic [tde_pkg::LETTER_W-1:0]   letter,
  input  logic                           last_letter,
  input  logic                           queue_full,
  input  logic                           clearing,
  output logic                           busy,
  output logic                           push,
  output tde_pkg::item_t                 item
);

  assign busy = queue_full || clearing;
  assign push = start && !busy;

  always_comb begin
    item.op         = opcode;
    item.letter     = letter;
    item.last       = last_letter;
    item.op_bad     = !(opcode == tde_pkg::OP_INSERT || opcode == tde_pkg::OP_SEARCH ||
                        opcode == tde_pkg::OP_PREFIX);
    item.letter_bad = int'(letter) >= tde_pkg::ALPHABET_SIZE;
  end

endmodule

/* hdl/tde_queue.sv */
// Short queue of classified letters between front and back.
module tde_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tde_pkg::item_t push_item,
  input  logic           pop,
  output tde_pkg::item_t head,
  output logic           empty,
  output logic           full
);

  tde_pkg::item_t                 entries [tde_pkg::QUEUE_DEPTH];
  logic [tde_pkg::QPTR_W-1:0]     wr_ptr;
  logic [tde_pkg::QPTR_W-1:0]     rd_ptr;
  logic [tde_pkg::QCNT_W-1:0]     count;

  assign empty = count == '0;
  assign full  = count == tde_pkg::QCNT_W'(tde_pkg::QUEUE_DEPTH);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (int'(wr_ptr) == tde_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (int'(rd_ptr) == tde_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/tde_back.sv */
// Back end: walks the child table, allocates nodes and issues results.
module tde_back (
  input  logic                          clk,
  input  logic                          rst,
  input  tde_pkg::item_t                head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          clearing,
  output logic                          done,
  output logic [tde_pkg::OP_W-1:0]      op_done,
  output logic [tde_pkg::ANS_W-1:0]     answer
);

  typedef enum logic [1:0] {ST_CLEAR, ST_FETCH, ST_EXEC} state_t;

  // Each slot holds the child index and, above it, that child's word-end mark.
  logic [tde_pkg::NODE_W:0] child_mem [tde_pkg::SLOT_COUNT];

  state_t                     state;
  logic [tde_pkg::SLOT_W-1:0] clr_addr;
  logic [tde_pkg::SLOT_W-1:0] slot_addr;
  logic [tde_pkg::NODE_W-1:0] cursor;
  logic [tde_pkg::FREE_W-1:0] next_free;
  logic                       missed;
  logic                       exhausted;
  tde_pkg::item_t             cur;
  logic [tde_pkg::NODE_W:0]   rd_data;

  logic                       fast;
  logic [tde_pkg::SLOT_W-1:0] head_slot;
  logic                       mem_re;
  logic                       mem_we;
  logic [tde_pkg::SLOT_W-1:0] mem_waddr;
  logic [tde_pkg::NODE_W:0]   mem_wdata;
  logic                       fast_missed;
  logic [tde_pkg::ANS_W-1:0]  fast_answer;

  logic [tde_pkg::NODE_W-1:0] rd_child;
  logic                       rd_mark;
  logic                       child_ok;
  logic                       is_ins;
  logic                       room;
  logic                       alloc;
  logic                       full_hit;
  logic                       miss_hit;
  logic [tde_pkg::NODE_W-1:0] new_cursor;
  logic [tde_pkg::ANS_W-1:0]  exec_answer;

  assign clearing = state == ST_CLEAR;

  always_comb begin
    fast      = head.op_bad || head.letter_bad || missed || exhausted;
    head_slot = tde_pkg::SLOT_W'(cursor) * tde_pkg::SLOT_W'(tde_pkg::ALPHABET_SIZE) +
                tde_pkg::SLOT_W'(head.letter);
    pop       = (state == ST_FETCH) && !empty;
    mem_re    = pop && !fast;

    fast_missed = missed || (!head.op_bad && head.letter_bad);
    if (head.op == tde_pkg::OP_INSERT && exhausted) begin
      fast_answer = tde_pkg::ANS_FULL;
    end else begin
      fast_answer = tde_pkg::ANS_NO;
    end

    rd_child   = rd_data[tde_pkg::NODE_W-1:0];
    rd_mark    = rd_data[tde_pkg::NODE_W];
    child_ok   = (rd_child != '0) &&
                 (tde_pkg::FREE_W'(rd_child) < tde_pkg::FREE_W'(tde_pkg::NODE_COUNT));
    is_ins     = cur.op == tde_pkg::OP_INSERT;
    room       = next_free < tde_pkg::FREE_W'(tde_pkg::NODE_COUNT);
    alloc      = !child_ok && is_ins && room;
    full_hit   = !child_ok && is_ins && !room;
    miss_hit   = !child_ok && !is_ins;
    new_cursor = child_ok ? rd_child : next_free[tde_pkg::NODE_W-1:0];

    priority if (full_hit) begin
      exec_answer = tde_pkg::ANS_FULL;
    end else if (miss_hit) begin
      exec_answer = tde_pkg::ANS_NO;
    end else if (cur.op == tde_pkg::OP_SEARCH) begin
      exec_answer = rd_mark ? tde_pkg::ANS_YES : tde_pkg::ANS_NO;
    end else begin
      exec_answer = tde_pkg::ANS_YES;
    end

    mem_we    = 1'b0;
    mem_waddr = slot_addr;
    mem_wdata = {cur.last, new_cursor};
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_EXEC: begin
        mem_we = alloc || (child_ok && is_ins && cur.last);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      child_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= child_mem[head_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      cursor    <= '0;
      next_free <= tde_pkg::FREE_W'(1);
      missed    <= 1'b0;
      exhausted <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == tde_pkg::SLOT_W'(tde_pkg::SLOT_COUNT - 1)) begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          if (!empty) begin
            if (!fast) begin
              cur       <= head;
              slot_addr <= head_slot;
              state     <= ST_EXEC;
            end else if (head.last) begin
              done    <= 1'b1;
              op_done <= head.op;
              answer  <= fast_answer;
              cursor    <= '0;
              missed    <= 1'b0;
              exhausted <= 1'b0;
            end else begin
              missed <= fast_missed;
            end
          end
        end
        ST_EXEC: begin
          state <= ST_FETCH;
          if (alloc) begin
            next_free <= next_free + 1'b1;
          end
          if (cur.last) begin
            done      <= 1'b1;
            op_done   <= cur.op;
            answer    <= exec_answer;
            cursor    <= '0;
            missed    <= 1'b0;
            exhausted <= 1'b0;
          end else begin
            if (child_ok || alloc) begin
              cursor <= new_cursor;
            end
            missed    <= miss_hit;
            exhausted <= full_hit;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  a_full_only_insert: assert property (@(posedge clk) disable iff (rst)
    done && answer == tde_pkg::ANS_FULL |-> op_done == tde_pkg::OP_INSERT)
    else $error("out-of-nodes answer on a non-insert word");

  a_walk_reset: assert property (@(posedge clk) disable iff (rst)
    done |-> (cursor == '0 && !missed && !exhausted))
    else $error("walk not back at the root after a result");

  a_exec_after_fetch: assert property (@(posedge clk) disable iff (rst)
    state == ST_EXEC |-> $past(state) == ST_FETCH)
    else $error("table step entered without a read");

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= tde_pkg::FREE_W'(tde_pkg::NODE_COUNT))
    else $error("node counter beyond the pool");

endmodule

/* hdl/trie_dictionary_engine.sv */
// Top level of the trie dictionary engine: front, queue and back joined.
//
// The engine keeps a dictionary trie and takes one letter of a word per
// start pulse, together with its opcode (insert, search, prefix test) and
// a last-letter flag; a letter is accepted at a clock edge with start high
// and busy low. After reset the child table is swept clear, one slot a
// cycle, and busy stays high until all NODE_COUNT * ALPHABET_SIZE slots
// are clear. A letter that walks the table goes through two back-end
// states: ST_FETCH reads the child slot addressed by the cursor and the
// letter, ST_EXEC follows or allocates the child and writes the slot back
// when an insert allocates or ends there. The next letter's read needs
// this cursor, so the table walk sets the pace. Letters that cannot move
// the cursor (unknown opcode, a letter outside the alphabet, or a word
// that has already missed or run out of nodes) are handled in ST_FETCH
// alone. A two-entry queue parts the front from the back, so start may
// be given while the back is still at work. The result of a word is shown
// on op_done and answer for exactly one cycle with done high; the
// receiver cannot stall it and must take it in that cycle.
module trie_dictionary_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tde_pkg::OP_W-1:0]      opcode,
  input  logic [tde_pkg::LETTER_W-1:0]  letter,
  input  logic                          last_letter,
  output logic                          busy,
  output logic                          done,
  output logic [tde_pkg::OP_W-1:0]      op_done,
  output logic [tde_pkg::ANS_W-1:0]     answer
);

  logic           push;
  logic           pop;
  logic           queue_full;
  logic           queue_empty;
  logic           clearing;
  tde_pkg::item_t in_item;
  tde_pkg::item_t head_item;

  // Accept and classify each letter; hold off while the queue is full or
  // the table is still being cleared.
  tde_front u_front (
    .start       (start),
    .opcode      (opcode),
    .letter      (letter),
    .last_letter (last_letter),
    .queue_full  (queue_full),
    .clearing    (clearing),
    .busy        (busy),
    .push        (push),
    .item        (in_item)
  );

  // Buffer classified letters so the front keeps accepting during table steps.
  tde_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (in_item),
    .pop       (pop),
    .head      (head_item),
    .empty     (queue_empty),
    .full      (queue_full)
  );

  // Walk the trie, allocate nodes and drive the result strobe.
  tde_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head_item),
    .empty    (queue_empty),
    .pop      (pop),
    .clearing (clearing),
    .done     (done),
    .op_done  (op_done),
    .answer   (answer)
  );

endmodule
